// File: rtl/sset_pkg.sv
// Shared types and constants for the stable sorted entry table.
// No dependencies; imported by every module of the block.
package sset_pkg;

  localparam int KEY_IN_W = 16;  // width of the key field on the port
  localparam int ID_IN_W  = 8;   // width of the identifier field on the port
  localparam int FIELD_W  = 5;   // width of the position and occupancy fields

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD_NEW   = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic gt;  // holds a live entry with a key above the command key
    logic eq;  // holds a live entry whose key and identifier match
  } cell_flags_t;

endpackage

// File: rtl/sset_cell.sv
// One slot of the entry chain: key and identifier registers plus compare.
// Depends on sset_pkg.
module sset_cell
  import sset_pkg::*;
#(
  parameter int KEY_BITS = 16,
  parameter int ID_BITS  = 8
) (
  input  logic                clk,
  input  cell_op_t            op,
  input  logic                valid,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [ID_BITS-1:0]  new_id,
  input  logic [KEY_BITS-1:0] lower_key,
  input  logic [ID_BITS-1:0]  lower_id,
  input  logic [KEY_BITS-1:0] upper_key,
  input  logic [ID_BITS-1:0]  upper_id,
  output cell_flags_t         flags,
  output logic [KEY_BITS-1:0] key,
  output logic [ID_BITS-1:0]  id
);

  logic [KEY_BITS-1:0] key_r;
  logic [ID_BITS-1:0]  id_r;

  always_comb begin
    flags.gt = valid && (key_r > new_key);
    flags.eq = valid && (key_r == new_key) && (id_r == new_id);
  end

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD_NEW: begin
        key_r <= new_key;
        id_r  <= new_id;
      end
      CELL_FROM_LOWER: begin
        key_r <= lower_key;
        id_r  <= lower_id;
      end
      CELL_FROM_UPPER: begin
        key_r <= upper_key;
        id_r  <= upper_id;
      end
      default: begin
        key_r <= key_r;
        id_r  <= id_r;
      end
    endcase
  end

  assign key = key_r;
  assign id  = id_r;

endmodule

// File: rtl/sset_locate.sv
// Lowest-hit finder over the cell flags: prefix OR, one-hot first hit, index.
// Depends on sset_pkg.
module sset_locate
  import sset_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic [DEPTH-1:0]         hit,
  output logic [DEPTH-1:0]         reach,
  output logic                     any,
  output logic [$clog2(DEPTH)-1:0] index
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [DEPTH-1:0] pre;
  logic [DEPTH-1:0] first;

  // log-depth prefix OR: bit i set when any hit sits at or below i
  always_comb begin
    pre = hit;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      pre = pre | (pre << s);
    end
  end

  assign reach = pre;
  assign any   = pre[DEPTH-1];
  assign first = hit & ~{pre[DEPTH-2:0], 1'b0};

  always_comb begin
    index = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        index = index | IDX_W'(i);
      end
    end
  end

endmodule

// File: rtl/stable_sorted_entry_table_core.sv
// Top level of the stable sorted entry table: command register, cell chain,
// result register. Depends on sset_pkg, sset_cell and sset_locate.
//
// Keeps up to DEPTH entries (key, identifier) in ascending key order in a
// chain of cells, each holding one entry and trading it with its neighbors.
// A word is accepted on any rising edge with start high and busy low; busy
// is only high while in reset and until the first clock edge after it,
// so a new word may follow in every cycle. Each accepted word executes in
// the cycle after acceptance against the whole chain at once (every cell
// compares in parallel, then loads the new entry, takes its lower neighbor's
// entry or its upper neighbor's entry), and its result is registered onto
// the out_ ports, marked by out_valid for exactly one cycle. The figure
// of one word per cycle is set by the single execute stage of the chain;
// a word sees every update made by the word before it. The receiver cannot
// stall: results must be taken as they come. Insert goes after all equal
// keys; a full table refuses it. Remove takes the lowest position whose key
// and identifier both match, or reports not found. Entries above the count
// are never read, so the cells need no clearing after reset.
module stable_sorted_entry_table_core
  import sset_pkg::*;
#(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16,
  parameter int ID_BITS  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_action,
  input  logic [KEY_IN_W-1:0] in_sort_key,
  input  logic [ID_IN_W-1:0]  in_entry_id,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [FIELD_W-1:0]  out_position,
  output logic [FIELD_W-1:0]  out_occupancy
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // ---------------------------------------------------------------------
  // Command register: hold the accepted word for its execute cycle
  // ---------------------------------------------------------------------
  logic                busy_r;
  logic                accept;
  logic                cmd_vld_r;
  logic                cmd_act_r;
  logic [KEY_BITS-1:0] cmd_key_r;
  logic [ID_BITS-1:0]  cmd_id_r;

  logic [KEY_BITS+KEY_IN_W-1:0] key_ext;
  logic [ID_BITS+ID_IN_W-1:0]   id_ext;

  // keep only the low KEY_BITS / ID_BITS of the port fields
  assign key_ext = {{KEY_BITS{1'b0}}, in_sort_key};
  assign id_ext  = {{ID_BITS{1'b0}}, in_entry_id};

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      cmd_vld_r <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      cmd_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_act_r <= in_action;
      cmd_key_r <= key_ext[KEY_BITS-1:0];
      cmd_id_r  <= id_ext[ID_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  cell_op_t            cell_op [DEPTH];
  cell_flags_t         cell_flags [DEPTH];
  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [ID_BITS-1:0]  cell_id [DEPTH];
  logic [DEPTH-1:0]    live;
  logic [DEPTH-1:0]    tail;
  logic [DEPTH-1:0]    gt_vec;
  logic [DEPTH-1:0]    eq_vec;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] lo_key;
    logic [ID_BITS-1:0]  lo_id;
    logic [KEY_BITS-1:0] up_key;
    logic [ID_BITS-1:0]  up_id;

    // chain ends have no neighbor outside; tie them to the command (a value shifted in lands above the count)
    if (i == 0) begin : g_first
      assign lo_key = cmd_key_r;
      assign lo_id  = cmd_id_r;
    end else begin : g_lower
      assign lo_key = cell_key[i-1];
      assign lo_id  = cell_id[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign up_key = cmd_key_r;
      assign up_id  = cmd_id_r;
    end else begin : g_upper
      assign up_key = cell_key[i+1];
      assign up_id  = cell_id[i+1];
    end

    assign live[i]   = CNT_W'(i) < cnt_r;
    assign tail[i]   = CNT_W'(i) == cnt_r;
    assign gt_vec[i] = cell_flags[i].gt;
    assign eq_vec[i] = cell_flags[i].eq;

    sset_cell #(
      .KEY_BITS (KEY_BITS),
      .ID_BITS  (ID_BITS)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .valid     (live[i]),
      .new_key   (cmd_key_r),
      .new_id    (cmd_id_r),
      .lower_key (lo_key),
      .lower_id  (lo_id),
      .upper_key (up_key),
      .upper_id  (up_id),
      .flags     (cell_flags[i]),
      .key       (cell_key[i]),
      .id        (cell_id[i])
    );
  end

  // ---------------------------------------------------------------------
  // Execute: decide every cell's move and the result
  // ---------------------------------------------------------------------
  logic             full;
  logic             do_insert;
  logic             do_remove;
  logic [DEPTH-1:0] gt_below;
  logic [DEPTH-1:0] load_vec;
  logic [DEPTH-1:0] loc_hit;
  logic [DEPTH-1:0] loc_reach;
  logic             loc_any;
  logic [IDX_W-1:0] loc_index;

  assign full      = cnt_r == CNT_W'(DEPTH);
  assign do_insert = cmd_vld_r && (cmd_act_r == ACT_INSERT);
  assign do_remove = cmd_vld_r && (cmd_act_r == ACT_REMOVE);
  assign gt_below  = {gt_vec[DEPTH-2:0], 1'b0};
  // the new entry lands on the first cell above all keys not greater
  assign load_vec  = ~gt_below & (gt_vec | tail);
  assign loc_hit   = do_insert ? load_vec : eq_vec;

  sset_locate #(
    .DEPTH (DEPTH)
  ) u_locate (
    .hit   (loc_hit),
    .reach (loc_reach),
    .any   (loc_any),
    .index (loc_index)
  );

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (do_insert && !full) begin
        if (gt_below[i]) begin
          cell_op[i] = CELL_FROM_LOWER;
        end else if (load_vec[i]) begin
          cell_op[i] = CELL_LOAD_NEW;
        end
      end else if (do_remove && loc_any && loc_reach[i]) begin
        // close the gap: everything at or above the match drops one slot
        cell_op[i] = CELL_FROM_UPPER;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Count and result register
  // ---------------------------------------------------------------------
  logic             res_vld_r;
  status_t          res_status_r;
  logic [IDX_W-1:0] res_pos_r;
  logic [CNT_W-1:0] res_occ_r;
  status_t          res_status_nxt;
  logic [IDX_W-1:0] res_pos_nxt;

  always_comb begin
    cnt_nxt        = cnt_r;
    res_status_nxt = ST_DONE;
    res_pos_nxt    = '0;
    if (do_insert) begin
      if (full) begin
        res_status_nxt = ST_FULL;
      end else begin
        res_pos_nxt = loc_index;
        cnt_nxt     = cnt_r + CNT_W'(1);
      end
    end else if (do_remove) begin
      if (loc_any) begin
        res_pos_nxt = loc_index;
        cnt_nxt     = cnt_r - CNT_W'(1);
      end else begin
        res_status_nxt = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      res_vld_r <= cmd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_vld_r) begin
      res_status_r <= res_status_nxt;
      res_pos_r    <= res_pos_nxt;
      res_occ_r    <= cnt_nxt;
    end
  end

  // fit position and occupancy to the 5-bit result fields
  logic [IDX_W+FIELD_W-1:0] pos_ext;
  logic [CNT_W+FIELD_W-1:0] occ_ext;

  assign pos_ext = {{FIELD_W{1'b0}}, res_pos_r};
  assign occ_ext = {{FIELD_W{1'b0}}, res_occ_r};

  assign out_valid     = res_vld_r;
  assign out_status    = res_status_r;
  assign out_position  = pos_ext[FIELD_W-1:0];
  assign out_occupancy = occ_ext[FIELD_W-1:0];

endmodule

// File: rtl/sset_checker.sv
// Port-level assertions for the stable sorted entry table, with its bind.
// Depends on sset_pkg and stable_sorted_entry_table_core.
module sset_checker
  import sset_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                in_action,
  input logic                out_valid,
  input logic [1:0]          out_status,
  input logic [FIELD_W-1:0]  out_position,
  input logic [FIELD_W-1:0]  out_occupancy
);

  logic acc;
  assign acc = start && !busy && rst_n;

  // one result strobe per accepted word, and only for an accepted word
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(acc, 2))
    else $error("result strobe does not follow an accepted word");

  // a full refusal only answers an insert
  a_full_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> ($past(in_action, 2) == ACT_INSERT))
    else $error("full status on a remove");

  // not found only answers a remove
  a_miss_on_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NOT_FOUND)) |-> ($past(in_action, 2) == ACT_REMOVE))
    else $error("not found status on an insert");

  // refused words report position zero
  a_refused_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DONE)) |-> (out_position == '0))
    else $error("refused word reports a nonzero position");

  // occupancy never exceeds the table size
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((DEPTH > 31) || (int'(out_occupancy) <= DEPTH)))
    else $error("occupancy above table depth");

endmodule

bind stable_sorted_entry_table_core sset_checker #(.DEPTH(DEPTH)) u_sset_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for stable_sorted_entry_table_core: directed and random
// insert/remove words, each checked against a behavioral table model.
// Depends on sset_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;
  import sset_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;  // far beyond the slowest correct run
  localparam int RANDOM_CHUNKS = 10;
  localparam int CHUNK_WORDS = 50;

  // One expected result word.
  typedef struct {
    status_t                status;
    logic [FIELD_W-1:0]     position;
    logic [FIELD_W-1:0]     occupancy;
  } table_result_t;

  // Scoreboard: mirrors the sorted table and queues the result each
  // accepted word must produce.
  class entry_table_scoreboard;
    logic [KEY_IN_W-1:0] key_q [TABLE_DEPTH];
    logic [ID_IN_W-1:0]  id_q [TABLE_DEPTH];
    int                  count;
    int                  errors;
    table_result_t       expected_q[$];

    function new();
      count = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted word to the mirrored table and queue its result.
    function void note_word(logic act, logic [KEY_IN_W-1:0] key, logic [ID_IN_W-1:0] id);
      table_result_t r;
      int slot;
      slot = count;
      r.status = ST_DONE;
      if (act == ACT_INSERT) begin
        if (count >= TABLE_DEPTH) begin
          // full table: refuse, leave everything alone
          r.status = ST_FULL;
          slot = 0;
        end else begin
          // land after every entry with a key equal or lower
          for (int i = 0; i < count; i++) begin
            if (key_q[i] > key) begin
              slot = i;
              break;
            end
          end
          for (int i = count; i > slot; i--) begin
            key_q[i] = key_q[i-1];
            id_q[i] = id_q[i-1];
          end
          key_q[slot] = key;
          id_q[slot] = id;
          count++;
        end
      end else begin
        // lowest matching position wins when pairs are duplicated
        for (int i = 0; i < count; i++) begin
          if (key_q[i] == key && id_q[i] == id) begin
            slot = i;
            break;
          end
        end
        if (slot >= count) begin
          r.status = ST_NOT_FOUND;
          slot = 0;
        end else begin
          for (int i = slot; i + 1 < count; i++) begin
            key_q[i] = key_q[i+1];
            id_q[i] = id_q[i+1];
          end
          count--;
        end
      end
      r.position = FIELD_W'(slot);
      r.occupancy = FIELD_W'(count);
      expected_q = {expected_q, r};
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one result word with the oldest expectation, field by field.
    task check_result(logic [1:0] st, logic [FIELD_W-1:0] pos, logic [FIELD_W-1:0] occ);
      table_result_t exp_r;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status=%0d pos=%0d occ=%0d",
                                  st, pos, occ));
        return;
      end
      exp_r = expected_q.pop_front();
      if (st !== exp_r.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, exp_r.status));
      if (pos !== exp_r.position)
        report_mismatch($sformatf("position %0d, expected %0d", pos, exp_r.position));
      if (occ !== exp_r.occupancy)
        report_mismatch($sformatf("occupancy %0d, expected %0d", occ, exp_r.occupancy));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_action = ACT_INSERT;
  logic [KEY_IN_W-1:0] in_sort_key = '0;
  logic [ID_IN_W-1:0]  in_entry_id = '0;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [FIELD_W-1:0]  out_position;
  logic [FIELD_W-1:0]  out_occupancy;

  entry_table_scoreboard sb = new();
  int cycle_count = 0;

  stable_sorted_entry_table_core #(
    .DEPTH   (TABLE_DEPTH),
    .KEY_BITS(KEY_IN_W),
    .ID_BITS (ID_IN_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_sort_key  (in_sort_key),
    .in_entry_id  (in_entry_id),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_position (out_position),
    .out_occupancy(out_occupancy)
  );

  // 4 ns period, 50% duty.
  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Monitor: everything is sampled at the rising edge, before the block's own
  // nonblocking updates land, so the values seen are the ones the edge takes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_word(in_action, in_sort_key, in_entry_id);
      if (out_valid)
        sb.check_result(out_status, out_position, out_occupancy);
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("** stable_sorted_entry_table_core: FAILED **");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it. Called at a
  // rising edge; returns at the edge that accepted the word, so the next
  // word can follow without dropping start.
  task automatic send_word(input logic act, input logic [KEY_IN_W-1:0] key,
                           input logic [ID_IN_W-1:0] id);
    start <= 1'b1;
    in_action <= act;
    in_sort_key <= key;
    in_entry_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for a burst of idle cycles.
  task automatic idle_burst(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop start and hold until every queued result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Keys crowd into a few narrow bands so equal keys and duplicate pairs
  // show up often; the rest are spread over the whole range.
  function automatic logic [KEY_IN_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return KEY_IN_W'($urandom_range(0, 7));
      1: return KEY_IN_W'(16'hFFF8 | $urandom_range(0, 7));
      2: return KEY_IN_W'(16'h8000 + $urandom_range(0, 3));
      default: return KEY_IN_W'($urandom);
    endcase
  endfunction

  function automatic logic [ID_IN_W-1:0] pick_id();
    if ($urandom_range(0, 1) == 0)
      return ID_IN_W'($urandom_range(0, 3));
    return ID_IN_W'($urandom);
  endfunction

  // Edge cases: empty-table remove, key extremes, equal keys in arrival
  // order, a duplicated pair, id mismatch on a matching key, fill to full,
  // refused insert, then removal at both ends.
  task automatic run_directed();
    send_word(ACT_REMOVE, 16'h1234, 8'h56);   // nothing stored yet
    send_word(ACT_INSERT, 16'hFFFF, 8'hFF);
    send_word(ACT_INSERT, 16'h0000, 8'h00);
    send_word(ACT_INSERT, 16'h8000, 8'h01);
    send_word(ACT_INSERT, 16'h8000, 8'h02);   // equal key lands after
    send_word(ACT_INSERT, 16'h8000, 8'h01);   // duplicate pair
    send_word(ACT_REMOVE, 16'h8000, 8'h03);   // key hits, id misses
    send_word(ACT_REMOVE, 16'h8000, 8'h01);   // takes the lower duplicate
    for (int k = 0; k < 12; k++)
      send_word(ACT_INSERT, 16'h1000 + KEY_IN_W'(k / 3) * 16'h0010, ID_IN_W'(k));
    send_word(ACT_INSERT, 16'h4242, 8'h42);   // table is full now
    send_word(ACT_REMOVE, 16'hFFFF, 8'hFF);   // top entry
    send_word(ACT_REMOVE, 16'h0000, 8'h00);   // bottom entry
  endtask

  // Random traffic in chunks; each chunk leans toward insert, toward remove or toward neither so
  // the fill level sweeps between empty and full. Most removes target an
  // entry that is present; the rest probe for misses.
  task automatic run_random();
    int ins_pct;
    int idle_pct;
    int slot;
    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      case ($urandom_range(0, 2))
        0: ins_pct = 15;
        1: ins_pct = 50;
        default: ins_pct = 85;
      endcase
      // last two chunks run back to back with no gaps
      if (c >= RANDOM_CHUNKS - 2)
        idle_pct = 0;
      else
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      for (int n = 0; n < CHUNK_WORDS; n++) begin
        if ($urandom_range(0, 99) < idle_pct)
          idle_burst($urandom_range(1, 18));
        if ($urandom_range(0, 99) < ins_pct) begin
          send_word(ACT_INSERT, pick_key(), pick_id());
        end else if (sb.count > 0 && $urandom_range(0, 99) < 75) begin
          slot = $urandom_range(0, sb.count - 1);
          send_word(ACT_REMOVE, sb.key_q[slot], sb.id_q[slot]);
        end else begin
          send_word(ACT_REMOVE, pick_key(), pick_id());
        end
      end
      // hold off once mid-run until the pipe is empty
      if (c == RANDOM_CHUNKS / 2)
        drain_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain_results();
    run_random();

    // wait out the tail, then a few cycles for any stray result
    drain_results();
    repeat (8) @(posedge clk);

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("** stable_sorted_entry_table_core: PASSED **");
    else
      $display("** stable_sorted_entry_table_core: FAILED **");
    $finish;
  end

endmodule
